// File: src/gfrc_pkg.sv
// gfrc_pkg: shared types and constants for the grid field-of-view ray caster
// no dependencies
`timescale 1ns / 1ps

package gfrc_pkg;

    // coordinate width; every coordinate used by the block stays below 127
    localparam int CW = 7;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_VIEW  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // bit lanes of one memory word
    localparam int PL_EXP = 0;
    localparam int PL_VIS = 1;
    localparam int PL_TRN = 2;

    // register indexes
    localparam logic [1:0] REG_MAP_WIDTH   = 2'd0;
    localparam logic [1:0] REG_MAP_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_VIEW_RADIUS = 2'd2;

    localparam logic [6:0] RST_MAP_WIDTH   = 7'd64;
    localparam logic [6:0] RST_MAP_HEIGHT  = 7'd64;
    localparam logic [6:0] RST_VIEW_RADIUS = 7'd8;

    typedef struct packed {
        t_op        op;
        logic [5:0] x;
        logic [5:0] y;
        logic       transparent;
    } t_fov_req;

    typedef struct packed {
        logic status;
        logic transparent;
        logic explored;
        logic visible;
    } t_fov_res;

    typedef struct packed {
        logic [2:0] we;
        logic [2:0] wd;
    } t_mem_wr;

endpackage

// File: src/gfrc_mem.sv
// gfrc_mem: tile memory, three one-bit lanes per word with lane write enables
// depends on gfrc_pkg
`timescale 1ns / 1ps

module gfrc_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic              i_clk,
    input  logic [AW-1:0]     i_addr,
    input  gfrc_pkg::t_mem_wr i_wr,
    output logic [2:0]        o_rdata
);
    import gfrc_pkg::*;

    logic [2:0] r_mem [DEPTH];
    logic [2:0] r_rdata;

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < 3; b++) begin
            if (i_wr.we[b]) begin
                r_mem[i_addr][b] <= i_wr.wd[b];
            end
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/gfrc_core.sv
// gfrc_core: sequencer with one shared squaring unit that walks bresenham rays
// depends on gfrc_pkg; drives the tile memory gfrc_mem
`timescale 1ns / 1ps

module gfrc_core #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int AW         = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  gfrc_pkg::t_fov_req  i_req,
    input  logic [6:0]          i_map_width,
    input  logic [6:0]          i_map_height,
    input  logic signed [6:0]   i_view_radius,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output gfrc_pkg::t_fov_res  o_res,
    output logic [AW-1:0]       o_mem_addr,
    output gfrc_pkg::t_mem_wr   o_mem_wr,
    input  logic [2:0]          i_mem_rdata
);
    import gfrc_pkg::*;

    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam logic [AW-1:0] LAST = AW'(CELLS - 1);

    typedef enum logic [10:0] {
        ST_RSTCLR = 11'b00000000001,
        ST_IDLE   = 11'b00000000010,
        ST_EXEC   = 11'b00000000100,
        ST_RDWAIT = 11'b00000001000,
        ST_CLEAR  = 11'b00000010000,
        ST_R2     = 11'b00000100000,
        ST_RAY    = 11'b00001000000,
        ST_SQX    = 11'b00010000000,
        ST_SQY    = 11'b00100000000,
        ST_NEXT   = 11'b01000000000,
        ST_DONE   = 11'b10000000000
    } t_state;

    function automatic logic [AW-1:0] f_addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
        f_addr = AW'(y) * AW'(MAX_WIDTH) + AW'(x);
    endfunction

    t_state r_state, n_state;
    t_fov_req r_req, n_req;
    t_fov_res r_res, n_res;
    logic [AW-1:0] r_cnt, n_cnt;
    logic [11:0] r_r2, n_r2, r_acc, n_acc;
    logic [CW-1:0] r_left, n_left, r_right, n_right, r_bottom, n_bottom;
    logic [CW-1:0] r_tx, n_tx, r_ty, n_ty, r_cx, n_cx, r_cy, n_cy;
    logic signed [1:0] r_px, n_px, r_py, n_py, r_qx, n_qx, r_qy, n_qy;
    logic [CW-1:0] r_major, n_major, r_minor, n_minor, r_n, n_n;
    logic signed [8:0] r_err, n_err;

    logic [CW-1:0] w, h, vx, vy, rad;
    logic [5:0] mul_a;
    logic [11:0] mul_p;
    logic signed [7:0] ox, oy, dx, dy;
    logic [CW-1:0] aox, aoy, adx, ady;
    logic signed [1:0] sdx, sdy;
    logic [12:0] d2;
    logic [7:0] rsum, cxs, cys;
    logic signed [8:0] e;
    logic signed [9:0] e2;
    logic out_map;

    assign w = (int'(i_map_width) > MAX_WIDTH) ? CW'(MAX_WIDTH) : i_map_width;
    assign h = (int'(i_map_height) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : i_map_height;
    assign vx = {1'b0, r_req.x};
    assign vy = {1'b0, r_req.y};
    assign rad = i_view_radius;
    assign out_map = (vx >= w) || (vy >= h);

    // shared squaring unit
    assign mul_p = mul_a * mul_a;

    assign ox = $signed({1'b0, r_cx}) - $signed({1'b0, vx});
    assign oy = $signed({1'b0, r_cy}) - $signed({1'b0, vy});
    assign aox = ox[7] ? CW'(-ox) : CW'(ox);
    assign aoy = oy[7] ? CW'(-oy) : CW'(oy);
    assign dx = $signed({1'b0, r_tx}) - $signed({1'b0, vx});
    assign dy = $signed({1'b0, r_ty}) - $signed({1'b0, vy});
    assign adx = dx[7] ? CW'(-dx) : CW'(dx);
    assign ady = dy[7] ? CW'(-dy) : CW'(dy);
    assign sdx = dx[7] ? -2'sd1 : ((dx != 8'sd0) ? 2'sd1 : 2'sd0);
    assign sdy = dy[7] ? -2'sd1 : ((dy != 8'sd0) ? 2'sd1 : 2'sd0);
    assign d2 = {1'b0, r_acc} + {1'b0, mul_p};
    assign rsum = {1'b0, vx} + {1'b0, rad} + 8'd1;

    always_comb begin
        n_state = r_state; n_req = r_req; n_res = r_res; n_cnt = r_cnt;
        n_r2 = r_r2; n_acc = r_acc;
        n_left = r_left; n_right = r_right; n_bottom = r_bottom;
        n_tx = r_tx; n_ty = r_ty; n_cx = r_cx; n_cy = r_cy;
        n_px = r_px; n_py = r_py; n_qx = r_qx; n_qy = r_qy;
        n_major = r_major; n_minor = r_minor; n_n = r_n; n_err = r_err;
        o_mem_addr = f_addr(r_cx, r_cy);
        o_mem_wr = '0;
        mul_a = '0;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        cxs = '0; cys = '0; e = '0; e2 = '0;

        unique case (r_state)
            ST_RSTCLR: begin
                o_mem_addr = r_cnt;
                o_mem_wr.we = '1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    n_cnt = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_req = i_req;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_mem_addr = f_addr(vx, vy);
                n_res = '0;
                n_state = ST_DONE;
                unique case (r_req.op)
                    OP_NONE: begin
                        n_state = ST_DONE;
                    end
                    OP_WRITE: begin
                        if (out_map) begin
                            n_res.status = 1'b1;
                        end else begin
                            o_mem_wr.we[PL_TRN] = 1'b1;
                            o_mem_wr.wd[PL_TRN] = r_req.transparent;
                        end
                    end
                    OP_READ: begin
                        if (out_map) n_res.status = 1'b1;
                        else n_state = ST_RDWAIT;
                    end
                    OP_VIEW: begin
                        n_cnt = '0;
                        if (out_map) n_res.status = 1'b1;
                        else n_state = ST_CLEAR;
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_RDWAIT: begin
                n_res.visible = i_mem_rdata[PL_VIS];
                n_res.explored = i_mem_rdata[PL_EXP];
                n_res.transparent = i_mem_rdata[PL_TRN];
                n_state = ST_DONE;
            end
            ST_CLEAR: begin
                o_mem_addr = r_cnt;
                o_mem_wr.we[PL_VIS] = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    n_cnt = '0;
                    n_state = i_view_radius[6] ? ST_DONE : ST_R2;
                end
            end
            ST_R2: begin
                mul_a = rad[5:0];
                n_r2 = mul_p;
                n_left = (vx >= rad) ? (vx - rad) : '0;
                n_right = (rsum > {1'b0, w}) ? w : CW'(rsum);
                n_bottom = (({1'b0, vy} + {1'b0, rad} + 8'd1) > {1'b0, h}) ? h
                           : CW'({1'b0, vy} + {1'b0, rad} + 8'd1);
                n_tx = (vx >= rad) ? (vx - rad) : '0;
                n_ty = (vy >= rad) ? (vy - rad) : '0;
                n_state = ST_RAY;
            end
            ST_RAY: begin
                if (ady > adx) begin
                    n_major = ady; n_minor = adx;
                    n_px = 2'sd0; n_py = sdy; n_qx = sdx; n_qy = 2'sd0;
                end else begin
                    n_major = adx; n_minor = ady;
                    n_px = sdx; n_py = 2'sd0; n_qx = 2'sd0; n_qy = sdy;
                end
                n_cx = vx; n_cy = vy; n_err = '0; n_n = '0;
                n_state = ST_SQX;
            end
            ST_SQX: begin
                mul_a = aox[5:0];
                n_acc = mul_p;
                n_state = ST_SQY;
            end
            ST_SQY: begin
                mul_a = aoy[5:0];
                if (d2 > {1'b0, r_r2}) begin
                    n_state = ST_NEXT;
                end else begin
                    o_mem_wr.we[PL_VIS] = 1'b1;
                    o_mem_wr.wd[PL_VIS] = 1'b1;
                    o_mem_wr.we[PL_EXP] = 1'b1;
                    o_mem_wr.wd[PL_EXP] = 1'b1;
                    if (!i_mem_rdata[PL_TRN] || (r_cx == r_tx && r_cy == r_ty)
                        || r_n == r_major) begin
                        n_state = ST_NEXT;
                    end else begin
                        cxs = {1'b0, r_cx} + {{6{r_px[1]}}, r_px};
                        cys = {1'b0, r_cy} + {{6{r_py[1]}}, r_py};
                        e = r_err + $signed({2'b00, r_minor});
                        e2 = {e, 1'b0};
                        if (e2 >= $signed({3'b000, r_major})) begin
                            cxs = cxs + {{6{r_qx[1]}}, r_qx};
                            cys = cys + {{6{r_qy[1]}}, r_qy};
                            n_err = e - $signed({2'b00, r_major});
                        end else begin
                            n_err = e;
                        end
                        n_cx = cxs[CW-1:0];
                        n_cy = cys[CW-1:0];
                        n_n = r_n + 1'b1;
                        n_state = ST_SQX;
                    end
                end
            end
            ST_NEXT: begin
                n_res = '0;
                if (r_tx + 1'b1 < r_right) begin
                    n_tx = r_tx + 1'b1;
                    n_state = ST_RAY;
                end else if (r_ty + 1'b1 < r_bottom) begin
                    n_ty = r_ty + 1'b1;
                    n_tx = r_left;
                    n_state = ST_RAY;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RSTCLR;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req; r_res <= n_res; r_r2 <= n_r2; r_acc <= n_acc;
        r_left <= n_left; r_right <= n_right; r_bottom <= n_bottom;
        r_tx <= n_tx; r_ty <= n_ty; r_cx <= n_cx; r_cy <= n_cy;
        r_px <= n_px; r_py <= n_py; r_qx <= n_qx; r_qy <= n_qy;
        r_major <= n_major; r_minor <= n_minor; r_n <= n_n; r_err <= n_err;
    end

    assign o_res = r_res;

    a_ray_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQX) |-> (r_cx < w && r_cy < h))
        else $error("ray left the map");
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQX) |-> (r_n <= r_major))
        else $error("ray ran past its end");
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> (r_state == ST_EXEC))
        else $error("accepted request not executed");
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_DONE) |-> (o_mem_wr.we == 3'b000))
        else $error("memory written while not busy");

endmodule

// File: src/grid_fov_ray_caster_top.sv
// grid_fov_ray_caster_top: register port, result register, core and tile memory
// depends on gfrc_pkg, gfrc_mem, gfrc_core
//
// channel   dir  handshake                 content
// s_axis    in   tvalid/tready             tuser op, tdata x/y/transparent
// m_axis    out  tvalid/tready             tuser status, tdata flags
// apb       in   psel/penable/pwrite       map_width, map_height, view_radius
//
// after reset the tile memory is cleared over its whole depth, no request taken meanwhile
// write and read requests go through the single memory port; unused requests just return
// a view request clears the visible lane of every tile, then squares the radius in a setup
// state, then casts one ray per target tile, squaring the offsets of each tile on its ray
// in turn on the one shared squaring unit
// one request at a time; a finished result waits in the output register
`timescale 1ns / 1ps

module grid_fov_ray_caster_top #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // tile_x[5:0], tile_y[11:6], transparent_in[12]
    input  logic [1:0]  i_s_axis_tuser,  // operation[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // visible_out[0], explored_out[1], transparent_out[2]
    output logic        o_m_axis_tuser,  // status[0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gfrc_pkg::*;

    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = $clog2(CELLS);

    logic [6:0] r_map_width, r_map_height, r_view_radius;
    logic r_oval;
    t_fov_res r_odata;
    t_fov_req req;
    t_fov_res res;
    logic res_valid, res_ready;
    logic [AW-1:0] mem_addr;
    t_mem_wr mem_wr;
    logic [2:0] mem_rdata;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width <= RST_MAP_WIDTH;
            r_map_height <= RST_MAP_HEIGHT;
            r_view_radius <= RST_VIEW_RADIUS;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_MAP_WIDTH:   r_map_width <= pwdata[6:0];
                REG_MAP_HEIGHT:  r_map_height <= pwdata[6:0];
                REG_VIEW_RADIUS: r_view_radius <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MAP_WIDTH:   prdata = {25'd0, r_map_width};
            REG_MAP_HEIGHT:  prdata = {25'd0, r_map_height};
            REG_VIEW_RADIUS: prdata = {25'd0, r_view_radius};
            default:         prdata = '0;
        endcase
    end

    assign req.op = t_op'(i_s_axis_tuser);
    assign req.x = i_s_axis_tdata[5:0];
    assign req.y = i_s_axis_tdata[11:6];
    assign req.transparent = i_s_axis_tdata[12];

    // output register
    assign res_ready = !r_oval || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_oval <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) r_odata <= res;
    end

    assign o_m_axis_tvalid = r_oval;
    assign o_m_axis_tdata = {5'd0, r_odata.transparent, r_odata.explored, r_odata.visible};
    assign o_m_axis_tuser = r_odata.status;

    gfrc_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_s_axis_tvalid),
        .o_req_ready   (o_s_axis_tready),
        .i_req         (req),
        .i_map_width   (r_map_width),
        .i_map_height  (r_map_height),
        .i_view_radius ($signed(r_view_radius)),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res),
        .o_mem_addr    (mem_addr),
        .o_mem_wr      (mem_wr),
        .i_mem_rdata   (mem_rdata)
    );

    gfrc_mem #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_addr  (mem_addr),
        .i_wr    (mem_wr),
        .o_rdata (mem_rdata)
    );

endmodule

// File: verif/grid_fov_ray_caster_top_test.sv
// grid_fov_ray_caster_top_test: self-checking bench for the grid field-of-view ray caster
// drives tile write, view, read and unused requests plus register writes, predicts every result
// depends on gfrc_pkg and grid_fov_ray_caster_top
`timescale 1ns / 1ps

module grid_fov_ray_caster_top_test;
    import gfrc_pkg::*;

    localparam int GW = 64;
    localparam int GH = 64;
    localparam int WATCH_LIMIT = 2000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = '0;
    logic [1:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    grid_fov_ray_caster_top #(.MAX_WIDTH(GW), .MAX_HEIGHT(GH)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid), .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata), .i_s_axis_tuser(i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata), .o_m_axis_tuser(o_m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #4 i_clk = ~i_clk;

    // predicted tile planes and registers
    bit       tile_trn [GW*GH];
    bit       tile_vis [GW*GH];
    bit       tile_exp [GW*GH];
    bit [6:0] map_w_reg = RST_MAP_WIDTH;
    bit [6:0] map_h_reg = RST_MAP_HEIGHT;
    bit [6:0] radius_reg = RST_VIEW_RADIUS;

    t_fov_res pending_flags [$];
    int  err_count = 0;
    int  req_count = 0;
    int  res_count = 0;
    int  view_count = 0;
    int  idle_cycles = 0;
    bit  steady = 1'b0;

    task automatic report(input string what, input int got, input int want);
        err_count++;
        $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, res_count);
    endtask

    function automatic int sgn(input int v);
        return (v > 0) - (v < 0);
    endfunction

    function automatic void cast_ray(input int sx, sy, ex, ey, r2);
        int dx, dy, px, py, qx, qy, major, minor, cx, cy, acc, t, ox, oy;
        dx = ex - sx; dy = ey - sy;
        px = sgn(dx); py = 0; qx = 0; qy = sgn(dy);
        major = dx < 0 ? -dx : dx;
        minor = dy < 0 ? -dy : dy;
        cx = sx; cy = sy; acc = 0;
        if (minor > major) begin
            t = major; major = minor; minor = t;
            t = px; px = qx; qx = t;
            t = py; py = qy; qy = t;
        end
        for (int n = 0; n <= major; n++) begin
            ox = cx - sx; oy = cy - sy;
            if (ox * ox + oy * oy > r2) break;
            tile_vis[cy*GW + cx] = 1'b1;
            tile_exp[cy*GW + cx] = 1'b1;
            if (!tile_trn[cy*GW + cx] || (cx == ex && cy == ey)) break;
            cx += px; cy += py;
            acc += minor;
            if (acc * 2 >= major) begin
                cx += qx; cy += qy;
                acc -= major;
            end
        end
    endfunction

    function automatic t_fov_res predict_tile_request(input t_op op, input int x, y,
                                                      input bit trn);
        t_fov_res res;
        int w, h, r, lo_x, lo_y, hi_x, hi_y, idx;
        res = '0;
        w = map_w_reg > GW ? GW : map_w_reg;
        h = map_h_reg > GH ? GH : map_h_reg;
        r = $signed(radius_reg);
        if (op == OP_NONE) return res;
        if (x >= w || y >= h) begin
            res.status = 1'b1;
            return res;
        end
        idx = y*GW + x;
        case (op)
            OP_WRITE: tile_trn[idx] = trn;
            OP_READ: begin
                res.visible = tile_vis[idx];
                res.explored = tile_exp[idx];
                res.transparent = tile_trn[idx];
            end
            default: begin
                foreach (tile_vis[i]) tile_vis[i] = 1'b0;
                if (r >= 0) begin
                    lo_x = x - r < 0 ? 0 : x - r;
                    lo_y = y - r < 0 ? 0 : y - r;
                    hi_x = x + r + 1 > w ? w : x + r + 1;
                    hi_y = y + r + 1 > h ? h : y + r + 1;
                    for (int ty = lo_y; ty < hi_y; ty++)
                        for (int tx = lo_x; tx < hi_x; tx++)
                            cast_ray(x, y, tx, ty, r*r);
                end
            end
        endcase
        return res;
    endfunction

    // one tile request; tvalid stays high afterwards until the next request or idle
    task automatic send_tile(input t_op op, input int x, y, input bit trn);
        @(negedge i_clk);
        if (!steady && $urandom_range(99) < 13) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= op;
        i_s_axis_tdata <= {3'b000, trn, y[5:0], x[5:0]};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_flags.push_back(predict_tile_request(op, x, y, trn));
        req_count++;
        if (op == OP_VIEW) view_count++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        wait (pending_flags.size() == 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
        drain();
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= {25'd0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_MAP_WIDTH:  map_w_reg = val;
            REG_MAP_HEIGHT: map_h_reg = val;
            default:        radius_reg = val;
        endcase
    endtask

    // receiver side
    always @(negedge i_clk)
        i_m_axis_tready <= steady || $urandom_range(99) >= 13;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            res_count++;
            if (pending_flags.size() == 0) begin
                report("unrequested result", o_m_axis_tdata, 0);
            end else begin
                t_fov_res want;
                want = pending_flags.pop_front();
                if (o_m_axis_tdata[0] != want.visible)
                    report("visible", o_m_axis_tdata[0], want.visible);
                if (o_m_axis_tdata[1] != want.explored)
                    report("explored", o_m_axis_tdata[1], want.explored);
                if (o_m_axis_tdata[2] != want.transparent)
                    report("transparent", o_m_axis_tdata[2], want.transparent);
                if (o_m_axis_tdata[7:3] != 5'd0)
                    report("tdata padding", o_m_axis_tdata[7:3], 0);
                if (o_m_axis_tuser != want.status)
                    report("status", o_m_axis_tuser, want.status);
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", pending_flags.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic test_defaults();
        send_tile(OP_READ, 0, 0, 1'b0);
        send_tile(OP_WRITE, 63, 63, 1'b1);
        send_tile(OP_READ, 63, 63, 1'b0);
        send_tile(OP_NONE, 63, 63, 1'b1);
        send_tile(OP_WRITE, 1, 0, 1'b1);
        send_tile(OP_WRITE, 2, 0, 1'b1);
        send_tile(OP_WRITE, 0, 1, 1'b1);
        send_tile(OP_VIEW, 0, 0, 1'b0);
        send_tile(OP_READ, 3, 0, 1'b0);
        send_tile(OP_READ, 0, 2, 1'b0);
        send_tile(OP_READ, 9, 0, 1'b0);
    endtask

    task automatic test_radius_edges();
        write_reg(REG_VIEW_RADIUS, 7'h7f);
        send_tile(OP_VIEW, 5, 5, 1'b0);
        send_tile(OP_READ, 0, 0, 1'b0);
        write_reg(REG_VIEW_RADIUS, 7'd0);
        send_tile(OP_VIEW, 63, 63, 1'b0);
        send_tile(OP_READ, 63, 63, 1'b0);
        write_reg(REG_VIEW_RADIUS, 7'd63);
        send_tile(OP_VIEW, 32, 32, 1'b0);
        send_tile(OP_READ, 0, 0, 1'b0);
        send_tile(OP_READ, 33, 32, 1'b0);
    endtask

    task automatic test_map_size();
        write_reg(REG_MAP_WIDTH, 7'd1);
        write_reg(REG_MAP_HEIGHT, 7'd1);
        send_tile(OP_WRITE, 1, 0, 1'b1);
        send_tile(OP_VIEW, 0, 1, 1'b0);
        send_tile(OP_READ, 0, 0, 1'b0);
        write_reg(REG_MAP_WIDTH, 7'd100);
        write_reg(REG_MAP_HEIGHT, 7'd127);
        write_reg(REG_VIEW_RADIUS, 7'd2);
        send_tile(OP_VIEW, 63, 0, 1'b0);
        send_tile(OP_READ, 62, 1, 1'b0);
    endtask

    // well-formed scenes around a viewer with some noise mixed in
    task automatic test_random_scenes();
        int vx, vy, w, h;
        for (int phase = 0; phase < 4; phase++) begin
            write_reg(REG_MAP_WIDTH, 7'($urandom_range(4, 64)));
            write_reg(REG_MAP_HEIGHT, 7'($urandom_range(4, 64)));
            write_reg(REG_VIEW_RADIUS, 7'($urandom_range(0, 5)));
            steady = (phase == 2);
            w = map_w_reg > GW ? GW : map_w_reg;
            h = map_h_reg > GH ? GH : map_h_reg;
            while (req_count < 40 + 15 * (phase + 1)) begin
                if ($urandom_range(9) == 0) begin
                    send_tile(t_op'($urandom_range(3)), $urandom_range(63),
                              $urandom_range(63), 1'($urandom_range(1)));
                end else begin
                    vx = $urandom_range(w - 1);
                    vy = $urandom_range(h - 1);
                    repeat ($urandom_range(2, 6))
                        send_tile(OP_WRITE, vx + $urandom_range(4) - 2 < 0 ? 0 :
                                  (vx + 2 >= w ? vx : vx + $urandom_range(2)),
                                  vy + ($urandom_range(1) && vy + 1 < h),
                                  $urandom_range(3) != 0);
                    send_tile(OP_VIEW, vx, vy, 1'b0);
                    repeat ($urandom_range(2, 5))
                        send_tile(OP_READ, $urandom_range(vx > 4 ? vx - 4 : 0, vx + 4),
                                  $urandom_range(vy > 4 ? vy - 4 : 0, vy + 4), 1'b0);
                end
            end
            steady = 1'b0;
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_defaults();
        test_radius_edges();
        test_map_size();
        test_random_scenes();
        drain();
        repeat (50) @(negedge i_clk);
        $display("covered %0d requests (%0d views) and %0d results", req_count, view_count,
                 res_count);
        $display("map sizes 1 to clamped, radius -1 to 63, opaque and clear tiles, noise ops");
        if (err_count == 0 && pending_flags.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
